// ===== sv/pdb_pkg.sv =====
`default_nettype none
package pdb_pkg;

  localparam int ByteWidth  = 8;
  localparam int NibWidth   = 4;
  localparam int ValueWidth = 32;
  localparam int AddrWidth  = 3;
  localparam int DataWidth  = 32;

  // Largest contribution of one byte is 9*10+9 = 99, which fits in 7 bits.
  localparam int AddendWidth = 7;

  localparam int QueueDepth = 4;

  localparam logic [ByteWidth-1:0] BlankReset = 8'h40;

  localparam logic [NibWidth-1:0] SignNeg  = 4'hD;
  localparam logic [NibWidth-1:0] SignPos  = 4'hC;
  localparam logic [NibWidth-1:0] SignUns  = 4'hF;
  localparam logic [NibWidth-1:0] MaxDigit = 4'd9;

  // Register index of blank_code on the configuration port.
  localparam logic RegBlankCode = 1'b0;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic                   last;
    logic [AddendWidth-1:0] addend;
    logic                   negate;
    logic                   sign_err;
    logic                   hi_err;
    logic                   lo_err;
    logic                   blank;
  } pdb_op_t;

endpackage
`default_nettype wire

// ===== sv/pdb_if.sv =====
`default_nettype none
interface pdb_byte_if;
  logic                           valid;
  logic                           ready;
  logic [pdb_pkg::ByteWidth-1:0]  data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pdb_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pdb_pkg::ValueWidth-1:0] value;
  logic                                 was_blank;
  logic                                 high_digit_error;
  logic                                 low_digit_error;
  logic                                 sign_error;

  modport source (output valid, output value, output was_blank, output high_digit_error,
                  output low_digit_error, output sign_error, input ready);
  modport sink   (input valid, input value, input was_blank, input high_digit_error,
                  input low_digit_error, input sign_error, output ready);
endinterface
`default_nettype wire

// ===== sv/packed_decimal_to_binary.sv =====
// Packed-decimal (COMP-3) field to 32-bit binary converter.
//
// field_bytes takes one byte of the field per transfer, high nibble first,
// with last_byte set on the final byte (digit plus sign nibble). results
// carries one item per field: the signed value wrapped modulo 2^32, a blank
// flag and the digit and sign error flags.
//
// A byte is classified as it is accepted and placed in a four-entry queue;
// the accumulator stage takes one entry per cycle, holding a final byte
// while a result is still pending, and loads the output register on the
// final byte. The block sustains one byte per cycle while results does not
// stall, limited by the single multiply-add of the accumulator stage.
//
// When results stalls, the accumulator keeps absorbing non-final bytes of the
// next field and stops at its final byte; the queue then fills and
// field_bytes.ready falls. Reset empties the queue, drops a pending result,
// clears the field state and sets blank_code to 0x40. blank_code is written
// over the APB port at address 0 and must only change while the block is idle.
`default_nettype none
module packed_decimal_to_binary #(
  parameter int FifoDepth = pdb_pkg::QueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pdb_byte_if.sink                           field_bytes,
  pdb_result_if.source                       results,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdb_pkg::AddrWidth-1:0] paddr,
  input  wire logic [pdb_pkg::DataWidth-1:0] pwdata,
  output logic      [pdb_pkg::DataWidth-1:0] prdata,
  output logic                               pready
);
  import pdb_pkg::*;

  logic [ByteWidth-1:0] blank_code;
  logic                 reg_sel;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  pdb_op_t              push_op;
  pdb_op_t              head_op;

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrWidth-1];
  assign prdata  = (reg_sel == RegBlankCode) ? DataWidth'(blank_code) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_code <= BlankReset;
    end else if (psel && penable && pwrite && pready && (reg_sel == RegBlankCode)) begin
      blank_code <= pwdata[ByteWidth-1:0];
    end
  end

  pdb_front u_front (
    .field_bytes (field_bytes),
    .blank_code  (blank_code),
    .full        (full),
    .push        (push),
    .op          (push_op)
  );

  pdb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .full    (full),
    .empty   (empty)
  );

  pdb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head_op (head_op),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule
`default_nettype wire

// ===== sv/pdb_front.sv =====
`default_nettype none
module pdb_front (
  pdb_byte_if.sink                      field_bytes,
  input  wire logic [pdb_pkg::ByteWidth-1:0] blank_code,
  input  wire logic                     full,
  output logic                          push,
  output pdb_pkg::pdb_op_t              op
);
  import pdb_pkg::*;

  logic [NibWidth-1:0]    hi;
  logic [NibWidth-1:0]    lo;
  logic                   hi_ok;
  logic                   lo_ok;
  logic [AddendWidth-1:0] hi_part;
  logic [AddendWidth-1:0] lo_part;

  assign field_bytes.ready = !full;
  assign push = field_bytes.valid && !full;

  always_comb begin
    hi      = field_bytes.data_byte[ByteWidth-1:NibWidth];
    lo      = field_bytes.data_byte[NibWidth-1:0];
    hi_ok   = (hi <= MaxDigit);
    lo_ok   = (lo <= MaxDigit);
    hi_part = '0;
    lo_part = '0;

    op.last  = field_bytes.last_byte;
    op.blank = (field_bytes.data_byte == '0) || (field_bytes.data_byte == blank_code);
    op.hi_err = !hi_ok;

    if (field_bytes.last_byte) begin
      // The final byte carries one digit and the sign nibble.
      if (hi_ok) begin
        hi_part = AddendWidth'(hi);
      end
      op.addend   = hi_part;
      op.lo_err   = 1'b0;
      op.negate   = (lo == SignNeg);
      op.sign_err = !(lo inside {SignPos, SignNeg, SignUns});
    end else begin
      if (hi_ok) begin
        hi_part = AddendWidth'({hi, 3'b000}) + AddendWidth'({hi, 1'b0});
      end
      if (lo_ok) begin
        lo_part = AddendWidth'(lo);
      end
      op.addend   = hi_part + lo_part;
      op.lo_err   = !lo_ok;
      op.negate   = 1'b0;
      op.sign_err = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pdb_fifo.sv =====
`default_nettype none
module pdb_fifo #(
  parameter int Depth = pdb_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pdb_pkg::pdb_op_t push_op,
  input  wire logic             pop,
  output pdb_pkg::pdb_op_t      head_op,
  output logic                  full,
  output logic                  empty
);
  import pdb_pkg::*;

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  pdb_op_t             entries [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
    logic [PtrWidth-1:0] r;
    if (p == PtrWidth'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full    = (count == CntWidth'(Depth));
  assign empty   = (count == '0);
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_push_notfull: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== sv/pdb_back.sv =====
`default_nettype none
module pdb_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pdb_pkg::pdb_op_t  head_op,
  input  wire logic              empty,
  output logic                   pop,
  pdb_result_if.source           results
);
  import pdb_pkg::*;

  logic [ValueWidth-1:0] acc;
  logic                  all_blank;
  logic                  hi_seen;
  logic                  lo_seen;
  logic                  out_valid;

  logic [ValueWidth-1:0] scaled;
  logic [ValueWidth-1:0] sum;
  logic [ValueWidth-1:0] final_val;
  logic                  blank_now;

  // A non-final byte only touches the accumulator; a final byte needs the output register.
  assign pop = !empty && (!head_op.last || !out_valid || results.ready);
  assign results.valid = out_valid;

  always_comb begin
    if (head_op.last) begin
      scaled = (acc << 3) + (acc << 1);
    end else begin
      scaled = (acc << 6) + (acc << 5) + (acc << 2);
    end
    sum       = scaled + ValueWidth'(head_op.addend);
    final_val = head_op.negate ? (~sum + 1'b1) : sum;
    blank_now = all_blank && head_op.blank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      all_blank <= 1'b1;
      hi_seen   <= 1'b0;
      lo_seen   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head_op.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head_op.last) begin
          if (blank_now) begin
            results.value            <= '0;
            results.was_blank        <= 1'b1;
            results.high_digit_error <= 1'b0;
            results.low_digit_error  <= 1'b0;
            results.sign_error       <= 1'b0;
          end else begin
            results.value            <= final_val;
            results.was_blank        <= 1'b0;
            results.high_digit_error <= hi_seen || head_op.hi_err;
            results.low_digit_error  <= lo_seen;
            results.sign_error       <= head_op.sign_err;
          end
          acc       <= '0;
          all_blank <= 1'b1;
          hi_seen   <= 1'b0;
          lo_seen   <= 1'b0;
        end else begin
          acc       <= sum;
          all_blank <= blank_now;
          hi_seen   <= hi_seen || head_op.hi_err;
          lo_seen   <= lo_seen || head_op.lo_err;
        end
      end
    end
  end

  a_field_cleared: assert property (@(posedge clk) disable iff (rst)
    (pop && head_op.last) |=> (acc == '0) && all_blank && !hi_seen && !lo_seen)
    else $error("field state not cleared after the final byte");
  a_blank_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && results.was_blank) |-> (results.value == '0) &&
      !results.high_digit_error && !results.low_digit_error && !results.sign_error)
    else $error("blank field result carries a value or a flag");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !(pop && head_op.last))
    else $error("final byte overwrote a pending result");

endmodule
`default_nettype wire
